// ----- sv/mlfd_pkg.sv -----
package mlfd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] MAGIC_WORD  = 32'hAABB_CCDD;
    localparam logic [15:0] GAP_RESET   = 16'd33;
    localparam logic [1:0]  LEN_LAST_IX = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       frame_kept;
    } result_t;

    // classified beat handed from front to back
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [31:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/mlfd_front.sv -----
module mlfd_front
    import mlfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  item_t     item,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [23:0] recent_reg, recent_next;
    logic [1:0]  len_ix_reg, len_ix_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] left_reg, left_next;
    logic        started_reg, started_next;

    logic        accept;
    logic [31:0] accum_new;
    logic        magic_hit;
    logic        left_last;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;

    always_comb
    begin
        accum_new = accum_reg;
        accum_new[len_ix_reg*8 +: 8] = accum_reg[len_ix_reg*8 +: 8] | item.data_byte;
    end

    assign magic_hit = ({recent_reg, item.data_byte} == MAGIC_WORD);
    assign left_last = (left_reg[31:1] == 31'd0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (len_ix_reg == LEN_LAST_IX)
                        phase_next = (accum_new == 32'd0) ? PH_HUNT : PH_PAY;
                end
                PH_PAY:
                begin
                    if (left_last)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = magic_hit ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    // datapath registers
    always_comb
    begin
        recent_next  = recent_reg;
        len_ix_next  = len_ix_reg;
        accum_next   = accum_reg;
        left_next    = left_reg;
        started_next = started_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (len_ix_reg == LEN_LAST_IX)
                    begin
                        len_ix_next  = 2'd0;
                        recent_next  = 24'd0;
                        accum_next   = 32'd0;
                        started_next = 1'b0;
                        left_next    = accum_new;
                    end
                    else
                    begin
                        len_ix_next = len_ix_reg + 2'd1;
                        accum_next  = accum_new;
                    end
                end
                PH_PAY:
                begin
                    if (left_last)
                    begin
                        recent_next  = 24'd0;
                        len_ix_next  = 2'd0;
                        accum_next   = 32'd0;
                        left_next    = 32'd0;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        left_next    = left_reg - 32'd1;
                        started_next = 1'b1;
                    end
                end
                default:
                begin
                    if (magic_hit)
                    begin
                        recent_next  = 24'd0;
                        len_ix_next  = 2'd0;
                        accum_next   = 32'd0;
                        left_next    = 32'd0;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        recent_next = {recent_reg[15:0], item.data_byte};
                    end
                end
            endcase
        end
    end

    // beats into the queue
    always_comb
    begin
        push                    = 1'b0;
        push_cmd.out_byte       = 8'd0;
        push_cmd.has_byte       = 1'b0;
        push_cmd.first_of_frame = 1'b0;
        push_cmd.last_of_frame  = 1'b0;
        push_cmd.now_ms         = item.now_ms;
        case (phase_reg)
            PH_LEN:
            begin
                if (len_ix_reg == LEN_LAST_IX && accum_new == 32'd0)
                begin
                    push                    = accept;
                    push_cmd.first_of_frame = 1'b1;
                    push_cmd.last_of_frame  = 1'b1;
                end
            end
            PH_PAY:
            begin
                push                    = accept;
                push_cmd.out_byte       = item.data_byte;
                push_cmd.has_byte       = 1'b1;
                push_cmd.first_of_frame = !started_reg;
                push_cmd.last_of_frame  = left_last;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            recent_reg  <= 24'd0;
            len_ix_reg  <= 2'd0;
            accum_reg   <= 32'd0;
            left_reg    <= 32'd0;
            started_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            recent_reg  <= recent_next;
            len_ix_reg  <= len_ix_next;
            accum_reg   <= accum_next;
            left_reg    <= left_next;
            started_reg <= started_next;
        end
    end

endmodule

// ----- sv/mlfd_queue.sv -----
module mlfd_queue
    import mlfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t q_status
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_cmd        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/mlfd_back.sv -----
module mlfd_back
    import mlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  q_status_t   q_status,
    input  cmd_t        pop_cmd,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    logic [15:0] gap_reg;
    logic [31:0] last_kept_reg, last_kept_next;
    logic        valid_reg, valid_next;
    result_t     result_reg, result_next;
    logic [31:0] elapsed;
    logic        kept;

    assign pop     = !q_status.empty && (!valid_reg || !result_stall);
    assign elapsed = pop_cmd.now_ms - last_kept_reg;
    assign kept    = pop_cmd.last_of_frame && (elapsed >= {16'd0, gap_reg});

    always_comb
    begin
        valid_next     = valid_reg && result_stall;
        result_next    = result_reg;
        last_kept_next = last_kept_reg;
        if (pop)
        begin
            valid_next                 = 1'b1;
            result_next.out_byte       = pop_cmd.out_byte;
            result_next.has_byte       = pop_cmd.has_byte;
            result_next.first_of_frame = pop_cmd.first_of_frame;
            result_next.last_of_frame  = pop_cmd.last_of_frame;
            result_next.frame_kept     = kept;
            if (kept)
                last_kept_next = pop_cmd.now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= GAP_RESET;
            last_kept_reg <= 32'd0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                gap_reg <= cfg_write_data;
            last_kept_reg <= last_kept_next;
            valid_reg     <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/magic_length_frame_deframer.sv -----
// magic-word, length-prefixed deframer: one stream beat (byte plus ms timestamp) is
// taken every cycle while the internal queue has room; a payload beat or empty-frame
// marker goes through a queue slot and the output register to the result port; the rate is
// set by the front classifier, which handles one byte per cycle; a four-entry queue
// and the output register let the input keep flowing through short result stalls,
// and when the queue fills item_stall rises until the result side drains it
module magic_length_frame_deframer
    import mlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    // result stream
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    // minimum gap between kept frames, in ms
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data
);

    q_status_t q_status;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      pop_cmd;

    // front: magic hunt, length capture, payload counting
    mlfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples classification from delivery
    mlfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // back: frame throttle decision and output register
    mlfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_status       (q_status),
        .pop_cmd        (pop_cmd),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

`ifndef SYNTHESIS
    // kept flag only rides on the last beat of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_kept |-> result.last_of_frame)
    else $error("frame_kept without last_of_frame");

    // empty-frame marker is a single beat with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_byte |->
            result.first_of_frame && result.last_of_frame && result.out_byte == 8'd0)
    else $error("malformed empty-frame marker");

    // input is held off only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> q_status.full && !q_status.empty)
    else $error("input stalled without a full queue");
`endif

endmodule

// ----- sim/deframer_frame_checker.sv -----
`timescale 1ns / 100ps

module deframer_frame_checker
    import mlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  result_t     result,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    output int          error_count,
    output int          waiting_count,
    output int          beats_in,
    output int          results_seen,
    output int          frames_done,
    output int          frames_kept,
    output int          empty_frames
);

    // own copy of the deframer state
    phase_t      hunt_phase;
    logic [23:0] history;
    logic [1:0]  len_ix;
    logic [31:0] len_acc;
    logic [31:0] bytes_left;
    logic        started;
    logic [31:0] last_kept_ms;
    logic [15:0] min_gap;

    result_t     expected_beats[$];

    task automatic clear_to_hunt();
        hunt_phase = PH_HUNT;
        history    = '0;
        len_ix     = '0;
        len_acc    = '0;
        bytes_left = '0;
        started    = 1'b0;
    endtask

    // frame passes the throttle if enough ms went by, wrapping
    function automatic logic passes_frame_gap(input logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - last_kept_ms;
        if (elapsed >= {16'd0, min_gap}) begin
            last_kept_ms = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic advance_deframe(input item_t beat);
        result_t r;
        logic    emit;
        r    = '0;
        emit = 1'b0;
        case (hunt_phase)
            PH_LEN: begin
                len_acc = len_acc | ({24'd0, beat.data_byte} << (8 * len_ix));
                if (len_ix == LEN_LAST_IX) begin
                    len_ix = '0;
                    if (len_acc == 0) begin
                        r.first_of_frame = 1'b1;
                        r.last_of_frame  = 1'b1;
                        r.frame_kept     = passes_frame_gap(beat.now_ms);
                        emit = 1'b1;
                        empty_frames++;
                        clear_to_hunt();
                    end
                    else begin
                        bytes_left = len_acc;
                        len_acc    = '0;
                        started    = 1'b0;
                        hunt_phase = PH_PAY;
                    end
                end
                else begin
                    len_ix = len_ix + 2'd1;
                end
            end
            PH_PAY: begin
                r.out_byte       = beat.data_byte;
                r.has_byte       = 1'b1;
                r.first_of_frame = !started;
                started = 1'b1;
                emit    = 1'b1;
                if (bytes_left <= 1) begin
                    r.last_of_frame = 1'b1;
                    r.frame_kept    = passes_frame_gap(beat.now_ms);
                    clear_to_hunt();
                end
                else begin
                    bytes_left = bytes_left - 1;
                end
            end
            default: begin
                if ({history, beat.data_byte} == MAGIC_WORD) begin
                    clear_to_hunt();
                    hunt_phase = PH_LEN;
                end
                else begin
                    hunt_phase = PH_HUNT;
                    history    = {history[15:0], beat.data_byte};
                end
            end
        endcase
        if (emit) begin
            expected_beats.push_back(r);
            if (r.last_of_frame) begin
                frames_done++;
                if (r.frame_kept)
                    frames_kept++;
            end
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        results_seen++;
        if (expected_beats.size() == 0) begin
            if (error_count < 10)
                $display("%0t: result beat with nothing expected: byte %02h has %b first %b last %b kept %b",
                         $time, got.out_byte, got.has_byte, got.first_of_frame,
                         got.last_of_frame, got.frame_kept);
            error_count++;
        end
        else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
                if (error_count < 10)
                    $display("%0t: expected byte %02h has %b first %b last %b kept %b, got byte %02h has %b first %b last %b kept %b",
                             $time, want.out_byte, want.has_byte, want.first_of_frame,
                             want.last_of_frame, want.frame_kept, got.out_byte, got.has_byte,
                             got.first_of_frame, got.last_of_frame, got.frame_kept);
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_to_hunt();
            last_kept_ms = '0;
            min_gap      = GAP_RESET;
            expected_beats.delete();
            error_count   = 0;
            waiting_count = 0;
            beats_in      = 0;
            results_seen  = 0;
            frames_done   = 0;
            frames_kept   = 0;
            empty_frames  = 0;
        end
        else begin
            if (result_valid && !result_stall)
                check_result(result);
            if (cfg_write_en)
                min_gap = cfg_write_data;
            if (item_valid && !item_stall) begin
                beats_in++;
                advance_deframe(item);
            end
            waiting_count = expected_beats.size();
        end
    end

endmodule

// ----- sim/magic_length_frame_deframer_tb.sv -----
`timescale 1ns / 100ps

module magic_length_frame_deframer_tb;
    import mlfd_pkg::*;

    // run is cut off here
    localparam int CYCLE_LIMIT = 600000;
    // beats of random traffic per gap setting
    localparam int PHASE_BEATS = 138;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;

    int error_count;
    int waiting_count;
    int beats_in;
    int results_seen;
    int frames_done;
    int frames_kept;
    int empty_frames;

    // stimulus bookkeeping
    int          beats_sent;
    int          cycles;
    int          gap_writes;
    int          cur_gap;
    int          in_mode;
    int          out_mode;
    int          hold_left;
    logic [31:0] sim_ms;
    int          gap_plan[5];

    always #6 clk = ~clk;

    magic_length_frame_deframer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // watches both channels, predicts every result beat and compares
    deframer_frame_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .error_count    (error_count),
        .waiting_count  (waiting_count),
        .beats_in       (beats_in),
        .results_seen   (results_seen),
        .frames_done    (frames_done),
        .frames_kept    (frames_kept),
        .empty_frames   (empty_frames)
    );

    // idle length for one side: mode 0 never idles, 1 now and then, 2 often;
    // most idles are short, about one in ten is long
    function automatic int idle_len(input int mode);
        int pct;
        pct = (mode == 2) ? 60 : (mode == 1) ? 20 : 0;
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // result side back-pressure, changed at the falling edge only
    initial
    begin
        result_stall = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else
            begin
                hold_left = idle_len(out_mode);
                if (hold_left > 0)
                begin
                    result_stall <= 1'b1;
                    hold_left--;
                end
                else
                begin
                    result_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result beats still expected",
                     cycles, waiting_count);
            $display("magic_length_frame_deframer_tb NOT OK");
            $finish;
        end
    end

    // one stream beat: optional idle first, then hold it until accepted
    task automatic send_beat(input logic [7:0] b, input logic [31:0] t);
        int idle;
        // reshuffle idling on both sides every 40 beats, so there are
        // stretches with no gaps at all as well as busy ones
        if (beats_sent % 40 == 0)
        begin
            in_mode  = $urandom_range(0, 2);
            out_mode = $urandom_range(0, 2);
        end
        idle = idle_len(in_mode);
        if (idle > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= {b, t};
        do
            @(posedge clk);
        while (item_stall);
        beats_sent++;
    endtask

    // n bytes of w, most significant first, all stamped with t
    task automatic send_word(input logic [31:0] w, input int n, input logic [31:0] t);
        for (int i = n - 1; i >= 0; i--)
            send_beat(w[8*i +: 8], t);
    endtask

    // wait until every expected beat is out, then let the pipe empty;
    // hunting and length beats give no result, so it waits on past the last one
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (waiting_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_min_gap(input int v);
        settle();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v[15:0];
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        cur_gap = v;
        gap_writes++;
    endtask

    // well-formed frame: some noise, maybe a partial magic, then magic,
    // length and payload; mostly short frames, a few empty or long ones
    task automatic send_random_frame();
        logic [31:0] len;
        int          pick;
        repeat ($urandom_range(0, 3))
            send_beat(8'($urandom_range(0, 255)), sim_ms);
        if ($urandom_range(0, 3) == 0)
            send_word(MAGIC_WORD >> 8, 3, sim_ms);
        // move time so that both kept and throttled frames show up
        if ($urandom_range(0, 15) == 0)
            sim_ms = $urandom();
        else
            sim_ms += $urandom_range(0, 2 * cur_gap + 2);
        send_word(MAGIC_WORD, 4, sim_ms);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = '0;
        else if (pick < 95)
            len = $urandom_range(1, 12);
        else
            len = $urandom_range(200, 300);
        // length goes out little-endian
        send_word({len[7:0], len[15:8], len[23:16], len[31:24]}, 4, sim_ms);
        repeat (len)
        begin
            sim_ms += $urandom_range(0, 1);
            send_beat(8'($urandom_range(0, 255)), sim_ms);
        end
    endtask

    // broken traffic: a cut-off magic word or plain random bytes
    task automatic send_noise();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
        begin
            send_word(MAGIC_WORD >> 8, $urandom_range(1, 3), sim_ms);
            b = 8'($urandom_range(0, 255));
            if (b == MAGIC_WORD[7:0])
                b = 8'h00;
            send_beat(b, sim_ms);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_beat(8'($urandom_range(0, 255)), sim_ms);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        beats_sent     = 0;
        cycles         = 0;
        gap_writes     = 0;
        cur_gap        = int'(GAP_RESET);
        in_mode        = 0;
        out_mode       = 0;
        sim_ms         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, with the gap at its reset value of 33
        // empty frame at the top of the time range: kept
        send_word(MAGIC_WORD, 4, 32'h0000_0000);
        send_word(32'h0000_0000, 4, 32'hFFFF_FFFF);
        // two-byte frame after the time wrapped, only 6 ms later: throttled;
        // payload ends in the first magic byte
        send_word(MAGIC_WORD, 4, 32'h0000_0000);
        send_word(32'h0200_0000, 4, 32'h0000_0000);
        send_word(32'h0000_FFAA, 2, 32'h0000_0005);
        // rest of a magic word right after the frame must not match, then a
        // slide by one onto the real magic; empty frame exactly at the gap
        send_word(32'h00BB_CCDD, 3, 32'h0000_0000);
        send_word(MAGIC_WORD, 4, 32'h0000_0000);
        send_word(32'h0000_0000, 4, 32'h0000_0020);

        // random traffic under several gap settings, extremes included
        gap_plan[0] = 0;
        gap_plan[1] = 65535;
        gap_plan[2] = $urandom_range(1, 200);
        gap_plan[3] = $urandom_range(0, 65535);
        gap_plan[4] = 1;
        for (int p = 0; p < 5; p++)
        begin
            set_min_gap(gap_plan[p]);
            while (beats_sent < 29 + (p + 1) * PHASE_BEATS)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_random_frame();
            end
        end

        // all-ones length: the frame never ends, payload just streams through
        send_word(MAGIC_WORD, 4, sim_ms);
        send_word(32'hFFFF_FFFF, 4, sim_ms);
        repeat (120)
            send_beat(8'($urandom_range(0, 255)), sim_ms);

        settle();
        repeat (10) @(negedge clk);

        $display("covered %0d stream beats and %0d result beats",
                 beats_in, results_seen);
        $display("%0d frames done (%0d kept, %0d empty) over %0d gap settings",
                 frames_done, frames_kept, empty_frames, gap_writes + 1);
        if (waiting_count != 0)
            $display("%0d expected result beats never arrived", waiting_count);
        if (error_count == 0 && waiting_count == 0)
            $display("magic_length_frame_deframer_tb OK");
        else
            $display("magic_length_frame_deframer_tb NOT OK");
        $finish;
    end

endmodule
